// ===== design/arx_pkg.sv =====
package arx_pkg;

    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int NUM_KS        = 8;
    localparam int NUM_REGS      = 6;
    localparam int DATA_W        = 64;
    localparam int POS_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int ROUND_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  cw_t;
    typedef logic [NUM_KS-1:0][WORD_W-1:0]     ks_t;
    typedef logic [NUM_REGS-1:0][DATA_W-1:0]   cfg_t;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd5;

    localparam word_t FIXED_0 = 32'hed21b71b;
    localparam word_t FIXED_1 = 32'he3b4d73a;
    localparam word_t FIXED_2 = 32'h85f2eb43;
    localparam word_t FIXED_3 = 32'h9b5240c2;

    // One queued beat: restart flag, keystream word position, data
    typedef struct packed {
        logic             restart;
        logic [POS_W-1:0] pos;
        logic [DATA_W-1:0] data;
    } item_t;

    function automatic word_t rol32(word_t x, int amt);
        return (x << amt) | (x >> (WORD_W - amt));
    endfunction

    function automatic cw_t load_state(cfg_t cfg);
        cw_t c;
        c = '0;
        for (int i = 0; i < 4; i++) begin
            c[4*i]     = cfg[i][DATA_W-1:WORD_W];
            c[4*i + 2] = cfg[i][WORD_W-1:0];
        end
        c[1]  = cfg[REG_NONCE_HI][DATA_W-1:WORD_W];
        c[3]  = cfg[REG_NONCE_HI][WORD_W-1:0];
        c[5]  = cfg[REG_NONCE_LO][DATA_W-1:WORD_W];
        c[7]  = cfg[REG_NONCE_LO][WORD_W-1:0];
        c[9]  = FIXED_0;
        c[11] = FIXED_1;
        c[13] = FIXED_2;
        c[15] = FIXED_3;
        return c;
    endfunction

    // One full round; the longest add-rotate chain is four updates deep.
    function automatic cw_t arx_round(cw_t c_in);
        cw_t c;
        c = c_in;
        c[8]  = c[8]  ^ rol32(c[10] + c[3], 7);
        c[15] = c[15] + rol32(c[14] ^ c[6], 21);
        c[9]  = c[9]  + rol32(c[11] ^ c[0], 17);
        c[5]  = c[5]  + rol32(c[7] ^ c[12], 9);
        c[2]  = c[2]  ^ rol32(c[2] + c[9], 13);
        c[11] = c[11] + rol32(c[9] ^ c[2], 19);
        c[4]  = c[4]  ^ rol32(c[4] + c[15], 6);
        c[6]  = c[6]  ^ rol32(c[6] + c[13], 14);
        c[13] = c[13] + rol32(c[12] ^ c[4], 9);
        c[0]  = c[0]  ^ rol32(c[0] + c[11], 7);
        c[7]  = c[7]  + rol32(c[5] ^ c[14], 21);
        c[14] = c[14] + rol32(c[13] + c[5], 14);
        c[10] = c[10] + rol32(c[8] + c[1], 13);
        c[3]  = c[3]  + rol32(c[1] ^ c[10], 19);
        c[12] = c[12] ^ rol32(c[15] + c[7], 6);
        c[1]  = c[1]  + rol32(c[3] ^ c[8], 17);
        return c;
    endfunction

    function automatic ks_t ks_mix(cw_t c);
        ks_t k;
        for (int i = 0; i < NUM_KS; i++) begin
            k[i] = c[i] ^ c[i + NUM_KS];
        end
        return k;
    endfunction

    function automatic cw_t cw_rotate(cw_t c);
        cw_t r;
        for (int i = 0; i < NUM_WORDS - 1; i++) begin
            r[i] = c[i + 1];
        end
        r[NUM_WORDS-1] = c[0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] ks_pick(ks_t k, logic [POS_W-1:0] p);
        return {k[{p, 1'b0}], k[{p, 1'b1}]};
    endfunction

endpackage

// ===== design/arx_front.sv =====
module arx_front
    import arx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    input  logic [DATA_W-1:0] data_in,
    input  logic              q_full,
    output logic              push,
    output item_t             push_item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_now;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // A restart begins a new block at word zero
    assign pos_now = restart ? '0 : pos_reg;

    assign push_item.restart = restart;
    assign push_item.pos     = pos_now;
    assign push_item.data    = data_in;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = pos_now + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== design/arx_queue.sv =====
module arx_queue
    import arx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== design/arx_back.sv =====
module arx_back
    import arx_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              head_valid,
    input  item_t             head_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] data_out
);

    localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUND_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    cw_t                cw_reg;
    cw_t                cw_next;
    ks_t                ks_reg;
    ks_t                ks_next;
    logic [CNT_W-1:0]   round_cnt_reg;
    logic [CNT_W-1:0]   round_cnt_next;
    logic [DATA_W-1:0]  data_reg;
    logic [DATA_W-1:0]  data_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    logic [DATA_W-1:0]  out_data_next;
    logic               out_free;
    cw_t                round_out;

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign round_out = arx_round(cw_reg);

    always_comb
    begin
        state_next     = state_reg;
        cw_next        = cw_reg;
        ks_next        = ks_reg;
        round_cnt_next = round_cnt_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_item.pos == '0)
                    begin
                        // word zero: take the beat and make a new block first
                        pop            = 1'b1;
                        data_next      = head_item.data;
                        round_cnt_next = '0;
                        state_next     = ST_ROUND;
                        if (head_item.restart)
                        begin
                            cw_next = load_state(cfg);
                        end
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next  = head_item.data ^ ks_pick(ks_reg, head_item.pos);
                    end
                end
            end
            ST_ROUND:
            begin
                round_cnt_next = round_cnt_reg + CNT_W'(1);
                if (round_cnt_reg == LAST_ROUND)
                begin
                    ks_next    = ks_mix(round_out);
                    cw_next    = cw_rotate(round_out);
                    state_next = ST_EMIT;
                end
                else
                begin
                    cw_next = round_out;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = data_reg ^ ks_pick(ks_reg, '0);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cw_reg        <= '0;
            ks_reg        <= '0;
            round_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cw_reg        <= cw_next;
            ks_reg        <= ks_next;
            round_cnt_reg <= round_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && pop && head_item.pos == '0) |=> state_reg == ST_ROUND)
        else $error("new block did not start rounds");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_cnt_reg == LAST_ROUND) |=> state_reg == ST_EMIT)
        else $error("rounds did not end after the last round");

    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.restart) |=> (cw_reg[9] == FIXED_0 && cw_reg[15] == FIXED_3))
        else $error("restart did not load the fixed words");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head_valid && state_reg == ST_IDLE))
        else $error("pop outside idle or from empty queue");
`endif

endmodule

// ===== design/arx_stream_cipher_xor_top.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  restart, data_in[63:0]
// output    out        out_valid / out_stall data_out[63:0]
// config    in         cfg_we               cfg_index[2:0], cfg_data[63:0]
//
// A beat at word positions 1..3 leaves once it heads the queue and the
// output is free. A beat at word position 0 (or with restart) first runs
// the rounds: the ARX round unit does one full round per cycle, then the
// emit state sends it once the output is free. No beat is popped meanwhile.
// Reset clears cipher state, keystream, word position, queue and registers.
// The front queues beats while the back stalls, until the queue is full.
module arx_stream_cipher_xor_top
    import arx_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart,
    input  logic [DATA_W-1:0]    data_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_W-1:0]    data_out
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // Key and nonce registers; they take effect at the next restart beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_0:    cfg_next[REG_KEY_0]    = cfg_data;
                REG_KEY_1:    cfg_next[REG_KEY_1]    = cfg_data;
                REG_KEY_2:    cfg_next[REG_KEY_2]    = cfg_data;
                REG_KEY_3:    cfg_next[REG_KEY_3]    = cfg_data;
                REG_NONCE_HI: cfg_next[REG_NONCE_HI] = cfg_data;
                REG_NONCE_LO: cfg_next[REG_NONCE_LO] = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: take beats and tag each with its keystream word position
    arx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .data_in   (data_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: decouple the front from the round unit
    arx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back: run rounds, form keystream, xor and hold the result
    arx_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out)
    );

endmodule

// ===== tb/arx_stream_cipher_xor_top_tb.sv =====
`timescale 1ns / 100ps

module arx_stream_cipher_xor_top_tb;

    import arx_pkg::*;

    localparam int ROUNDS        = ROUND_COUNT_DEF;
    localparam int RANDOM_BEATS  = 1950;
    localparam int KEY_PHASES    = 8;
    localparam int MAX_REPORTS   = 10;
    // Round unit plus emit state, with margin for the input queue
    localparam int TAIL_CYCLES   = 3 * (ROUNDS + 2);

    // Indexes past the register file; writes there must leave the key alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(NUM_REGS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
        REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3, REG_NONCE_HI, REG_NONCE_LO
    };

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_ONEHOT} fill_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_t;

    typedef struct packed {
        logic              restart;
        logic [DATA_W-1:0] data;
    } beat_t;

    // Directed beats. The key registers hold their reset value for the
    // first rows and all ones from KEYS_ALL_ONES_AT on. The rows before the
    // first restart see a zero keystream; every row goes through the predictor.
    localparam int KEYS_ALL_ONES_AT = 7;
    localparam int DIRECTED_BEATS   = 20;
    localparam beat_t DIRECTED [DIRECTED_BEATS] = '{
        // all-zero cipher state, never restarted
        '{1'b0, 64'h0000000000000000},
        '{1'b0, 64'hffffffffffffffff},
        '{1'b0, 64'h0123456789abcdef},
        '{1'b0, 64'h8000000000000001},
        // second block from the zero state
        '{1'b0, 64'h0000000000000000},
        // restart with registers still at reset
        '{1'b1, 64'h0000000000000000},
        '{1'b0, 64'hffffffffffffffff},
        // all-ones key and nonce from here
        '{1'b1, 64'h0000000000000000},
        // back-to-back restart, second one lands at word position 1
        '{1'b1, 64'h0000000000000000},
        '{1'b0, 64'hffffffffffffffff},
        // restart at word position 2
        '{1'b1, 64'hfedcba9876543210},
        '{1'b0, 64'h0000000000000000},
        '{1'b0, 64'h0000000000000000},
        // restart at word position 3
        '{1'b1, 64'hffffffffffffffff},
        '{1'b0, 64'h5555555555555555},
        '{1'b0, 64'haaaaaaaaaaaaaaaa},
        '{1'b0, 64'h0000000000000000},
        // run into the next block without a restart
        '{1'b0, 64'hffffffffffffffff},
        '{1'b0, 64'h0000000000000000},
        '{1'b0, 64'h00000000ffffffff}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 restart   = 1'b0;
    logic [DATA_W-1:0]    data_in   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DATA_W-1:0]    data_out;

    // Predictor state: register file, cipher words, keystream, word position
    logic [DATA_W-1:0] key_regs [NUM_REGS];
    word_t             cipher_state [NUM_WORDS];
    word_t             key_stream [NUM_KS];
    logic [POS_W-1:0]  word_pos;

    // Expected ciphertext words, oldest first
    logic [DATA_W-1:0] cipher_out_q [$];
    logic [DATA_W-1:0] want_word;
    int                mismatch_count = 0;
    int                out_count = 0;
    int                burst_left = 0;

    arx_stream_cipher_xor_top #(
        .ROUND_COUNT (ROUNDS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #6ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // Rebuild the cipher words from key, nonce and the four fixed words
    function automatic void reload_state();
        for (int i = 0; i < 4; i++)
        begin
            cipher_state[4*i]     = key_regs[i][DATA_W-1:WORD_W];
            cipher_state[4*i + 2] = key_regs[i][WORD_W-1:0];
        end
        cipher_state[1]  = key_regs[REG_NONCE_HI][DATA_W-1:WORD_W];
        cipher_state[3]  = key_regs[REG_NONCE_HI][WORD_W-1:0];
        cipher_state[5]  = key_regs[REG_NONCE_LO][DATA_W-1:WORD_W];
        cipher_state[7]  = key_regs[REG_NONCE_LO][WORD_W-1:0];
        cipher_state[9]  = FIXED_0;
        cipher_state[11] = FIXED_1;
        cipher_state[13] = FIXED_2;
        cipher_state[15] = FIXED_3;
    endfunction

    // Run the rounds, fold out eight keystream words, rotate the word array
    function automatic void advance_block();
        word_t c [NUM_WORDS];
        word_t head;
        c = cipher_state;
        for (int r = 0; r < ROUNDS; r++)
        begin
            c[8]  ^= rotl(c[10] + c[3], 7);
            c[15] += rotl(c[14] ^ c[6], 21);
            c[9]  += rotl(c[11] ^ c[0], 17);
            c[5]  += rotl(c[7] ^ c[12], 9);
            c[2]  ^= rotl(c[2] + c[9], 13);
            c[11] += rotl(c[9] ^ c[2], 19);
            c[4]  ^= rotl(c[4] + c[15], 6);
            c[6]  ^= rotl(c[6] + c[13], 14);
            c[13] += rotl(c[12] ^ c[4], 9);
            c[0]  ^= rotl(c[0] + c[11], 7);
            c[7]  += rotl(c[5] ^ c[14], 21);
            c[14] += rotl(c[13] + c[5], 14);
            c[10] += rotl(c[8] + c[1], 13);
            c[3]  += rotl(c[1] ^ c[10], 19);
            c[12] ^= rotl(c[15] + c[7], 6);
            c[1]  += rotl(c[3] ^ c[8], 17);
        end
        for (int i = 0; i < NUM_KS; i++)
        begin
            key_stream[i] = c[i] ^ c[i + NUM_KS];
        end
        head = c[0];
        for (int i = 0; i < NUM_WORDS - 1; i++)
        begin
            c[i] = c[i + 1];
        end
        c[NUM_WORDS-1] = head;
        cipher_state = c;
    endfunction

    function automatic logic [DATA_W-1:0] xor_keystream(logic rs, logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] ks;
        if (rs)
        begin
            reload_state();
            word_pos = '0;
        end
        if (word_pos == '0)
        begin
            advance_block();
        end
        ks = {key_stream[2*word_pos], key_stream[2*word_pos + 1]};
        word_pos = word_pos + 1'b1;
        return d ^ ks;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Present one beat and hold it until the block takes it, then log the
    // expected ciphertext. Valid stays high afterwards until the caller
    // either presents the next beat or idles.
    task automatic send_beat(logic rs, logic [DATA_W-1:0] d);
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= rs;
        data_in  <= d;
        do @(posedge clk); while (in_stall);
        cipher_out_q.push_back(xor_keystream(rs, d));
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Burst pacing: a random gap opens every burst; one burst in four is
    // long, which gives stretches with no sender idling at all
    task automatic pace();
        if (burst_left == 0)
        begin
            idle_cycles($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Drop valid and wait until every logged beat has come back
    task automatic drain();
        idle_cycles(1);
        while (cipher_out_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx < NUM_REGS)
        begin
            key_regs[idx] = val;
        end
    endtask

    function automatic logic [DATA_W-1:0] fill_value(fill_t f);
        case (f)
            FILL_ZERO:   return '0;
            FILL_ONES:   return '1;
            FILL_ONEHOT: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default:     return {$urandom, $urandom};
        endcase
    endfunction

    // Load a whole key and nonce set, poke both spare indexes, release we.
    // Call only with the block drained.
    task automatic load_key_set(fill_t f);
        foreach (REG_ORDER[i])
        begin
            write_reg(REG_ORDER[i], fill_value(f));
        end
        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: stall in modes of random length, from none at all to
    // long holds, so stalls hit every point of the round schedule
    // ------------------------------------------------------------------
    initial
    begin : stall_pattern
        stall_t mode;
        int     left;
        mode = STALL_NONE;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = stall_t'($urandom_range(0, 3));
                left = $urandom_range(8, 120);
            end
            left--;
            case (mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((left % 24) < 16);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output check: every accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_fail(string what, logic [DATA_W-1:0] exp_w,
                               logic [DATA_W-1:0] got_w);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%s at output beat %0d: expected %016h, got %016h",
                     what, out_count, exp_w, got_w);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_out_q.size() == 0)
            begin
                report_fail("unexpected beat", '0, data_out);
            end
            else
            begin
                want_word = cipher_out_q.pop_front();
                if (data_out !== want_word)
                begin
                    report_fail("data_out mismatch", want_word, data_out);
                end
            end
            out_count++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int per_phase;
        int sent;
        int msg_len;
        logic lead_restart;

        foreach (key_regs[i]) key_regs[i] = '0;
        foreach (cipher_state[i]) cipher_state[i] = '0;
        foreach (key_stream[i]) key_stream[i] = '0;
        word_pos = '0;

        // Hold reset, then release it away from the rising edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats; switch the key set to all ones at the marked row
        for (int i = 0; i < DIRECTED_BEATS; i++)
        begin
            if (i == KEYS_ALL_ONES_AT)
            begin
                drain();
                load_key_set(FILL_ONES);
            end
            pace();
            send_beat(DIRECTED[i].restart, DIRECTED[i].data);
        end

        // Random messages, one key set loaded per phase. Most messages open
        // with a restart; a few continue the old stream, and the odd beat
        // restarts mid-block. A new key set only bites at the next restart.
        per_phase = RANDOM_BEATS / KEY_PHASES;
        for (int p = 0; p < KEY_PHASES; p++)
        begin
            drain();
            load_key_set(fill_t'(p % 4));
            sent = 0;
            while (sent < per_phase)
            begin
                msg_len      = $urandom_range(1, 40);
                lead_restart = ($urandom_range(0, 9) != 0);
                for (int k = 0; k < msg_len && sent < per_phase; k++)
                begin
                    pace();
                    send_beat((k == 0) ? lead_restart : ($urandom_range(0, 63) == 0),
                              pick_data());
                    sent++;
                end
            end
        end

        // Let the last beats come back, then watch for stray output
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && cipher_out_q.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/arx_pkg.sv
design/arx_front.sv
design/arx_queue.sv
design/arx_back.sv
design/arx_stream_cipher_xor_top.sv
tb/arx_stream_cipher_xor_top_tb.sv
